@@ rtl/md5he_pkg.sv @@
package md5he_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_CLOAD,
        ST_CPRE,
        ST_ROUND,
        ST_ADD,
        ST_DEC
    } state_t;

    typedef logic [31:0] word_t;

    localparam word_t CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam word_t PAD_MARK = 32'h00000080;

    localparam word_t K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] S_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] word_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'((r4 << 2) + r4 + 4'd1);
            2'd2:    idx = 4'((r4 << 1) + r4 + 4'd5);
            default: idx = 4'((r4 << 3) - r4);
        endcase
        return idx;
    endfunction

    function automatic word_t rotl(input word_t v, input logic [4:0] amount);
        logic [63:0] dbl;
        dbl = {v, v} << amount;
        return dbl[63:32];
    endfunction

endpackage

@@ rtl/md5he_if.sv @@
interface md5he_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;

    modport source (output valid, output data_byte, output byte_present, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_present, input last,
                    output ready);
endinterface

interface md5he_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, input ready);
    modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                    input digest_d, output ready);
endinterface

@@ rtl/md5_hash_engine.sv @@
// Each message byte request is taken while the engine is idle; a full 64-byte block starts
// the compression, one round per cycle reading the block memory, and no further request is
// taken until it ends. A last request adds padding writes and one or two compressions; the
// digest is then registered, waiting while the output still holds an untaken digest.
// Reset clears the chaining value to the initial words, the length to zero, the output
// valid, and returns the engine to idle; the block memory needs no clearing.
module md5_hash_engine (
    input  logic         clk,
    input  logic         rst_n,
    md5he_in_if.sink     message,
    md5he_out_if.source  digest
);

    md5he_pkg::state_t state_reg, state_next;

    md5he_pkg::word_t  block_mem [16];
    md5he_pkg::word_t  mem_q;
    logic [3:0]        raddr;
    logic              we;
    logic [3:0]        waddr;
    md5he_pkg::word_t  wdata;

    md5he_pkg::word_t  chain_reg [4];
    md5he_pkg::word_t  chain_next [4];
    md5he_pkg::word_t  round_reg [4];
    md5he_pkg::word_t  round_next [4];
    md5he_pkg::word_t  pre_reg, pre_next;
    md5he_pkg::word_t  acc_reg, acc_next;
    logic [63:0]       total_reg, total_next;
    logic [5:0]        rnd_reg, rnd_next;
    logic [4:0]        wptr_reg, wptr_next;
    logic              extra_reg, extra_next;
    logic              in_pad_reg, in_pad_next;
    logic              final_reg, final_next;
    logic              last_pend_reg, last_pend_next;
    logic              out_valid_reg, out_valid_next;
    md5he_pkg::word_t  dig_reg [4];
    md5he_pkg::word_t  dig_next [4];

    logic [5:0]        pos;
    logic [4:0]        shamt;
    md5he_pkg::word_t  placed;
    md5he_pkg::word_t  mix;
    md5he_pkg::word_t  new_b;
    logic [63:0]       bit_len;
    logic [4:0]        limit;
    logic              accept;

    assign pos     = total_reg[5:0];
    assign shamt   = {pos[1:0], 3'b000};
    assign placed  = acc_reg | ({24'd0, message.data_byte} << shamt);
    assign bit_len = {total_reg[60:0], 3'b000};
    assign limit   = extra_reg ? 5'd16 : 5'd14;
    assign accept  = message.valid && message.ready;

    assign message.ready   = (state_reg == md5he_pkg::ST_IDLE);
    assign digest.valid    = out_valid_reg;
    assign digest.digest_a = dig_reg[0];
    assign digest.digest_b = dig_reg[1];
    assign digest.digest_c = dig_reg[2];
    assign digest.digest_d = dig_reg[3];

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    mix = (round_reg[1] & round_reg[2]) | (~round_reg[1] & round_reg[3]);
            2'd1:    mix = (round_reg[3] & round_reg[1]) | (~round_reg[3] & round_reg[2]);
            2'd2:    mix = round_reg[1] ^ round_reg[2] ^ round_reg[3];
            default: mix = round_reg[2] ^ (round_reg[1] | ~round_reg[3]);
        endcase
        new_b = round_reg[1] + md5he_pkg::rotl(mix + pre_reg, md5he_pkg::S_TAB[{rnd_reg[5:4],
                rnd_reg[1:0]}]);
    end

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        round_next     = round_reg;
        pre_next       = pre_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        rnd_next       = rnd_reg;
        wptr_next      = wptr_reg;
        extra_next     = extra_reg;
        in_pad_next    = in_pad_reg;
        final_next     = final_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg && !digest.ready;
        dig_next       = dig_reg;
        we             = 1'b0;
        waddr          = pos[5:2];
        wdata          = '0;
        raddr          = 4'd0;

        case (state_reg)
            md5he_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (message.byte_present)
                    begin
                        acc_next   = placed;
                        total_next = total_reg + 64'd1;
                        if (pos[1:0] == 2'd3)
                        begin
                            we       = 1'b1;
                            wdata    = placed;
                            acc_next = '0;
                        end
                        if (pos == 6'd63)
                        begin
                            last_pend_next = message.last;
                            state_next     = md5he_pkg::ST_CLOAD;
                        end
                        else if (message.last)
                        begin
                            state_next = md5he_pkg::ST_PAD;
                        end
                    end
                    else if (message.last)
                    begin
                        state_next = md5he_pkg::ST_PAD;
                    end
                end
            end
            md5he_pkg::ST_PAD:
            begin
                we             = 1'b1;
                wdata          = acc_reg | (md5he_pkg::PAD_MARK << shamt);
                acc_next       = '0;
                wptr_next      = {1'b0, pos[5:2]} + 5'd1;
                extra_next     = (pos[5:3] == 3'b111);
                in_pad_next    = 1'b1;
                last_pend_next = 1'b0;
                state_next     = md5he_pkg::ST_ZERO;
            end
            md5he_pkg::ST_ZERO:
            begin
                if (wptr_reg == limit)
                begin
                    if (extra_reg)
                    begin
                        extra_next = 1'b0;
                        state_next = md5he_pkg::ST_CLOAD;
                    end
                    else
                    begin
                        state_next = md5he_pkg::ST_LEN_LO;
                    end
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = wptr_reg[3:0];
                    wptr_next = wptr_reg + 5'd1;
                end
            end
            md5he_pkg::ST_LEN_LO:
            begin
                we         = 1'b1;
                waddr      = 4'd14;
                wdata      = bit_len[31:0];
                state_next = md5he_pkg::ST_LEN_HI;
            end
            md5he_pkg::ST_LEN_HI:
            begin
                we         = 1'b1;
                waddr      = 4'd15;
                wdata      = bit_len[63:32];
                final_next = 1'b1;
                state_next = md5he_pkg::ST_CLOAD;
            end
            md5he_pkg::ST_CLOAD:
            begin
                raddr      = md5he_pkg::word_index(6'd0);
                round_next = chain_reg;
                state_next = md5he_pkg::ST_CPRE;
            end
            md5he_pkg::ST_CPRE:
            begin
                raddr      = md5he_pkg::word_index(6'd1);
                pre_next   = round_reg[0] + md5he_pkg::K_TAB[0] + mem_q;
                rnd_next   = 6'd0;
                state_next = md5he_pkg::ST_ROUND;
            end
            md5he_pkg::ST_ROUND:
            begin
                raddr         = md5he_pkg::word_index(rnd_reg + 6'd2);
                pre_next      = round_reg[3] + md5he_pkg::K_TAB[rnd_reg + 6'd1] + mem_q;
                round_next[0] = round_reg[3];
                round_next[1] = new_b;
                round_next[2] = round_reg[1];
                round_next[3] = round_reg[2];
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = md5he_pkg::ST_ADD;
                end
            end
            md5he_pkg::ST_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + round_reg[i];
                end
                state_next = md5he_pkg::ST_DEC;
            end
            md5he_pkg::ST_DEC:
            begin
                if (final_reg)
                begin
                    if (!out_valid_reg || digest.ready)
                    begin
                        dig_next       = chain_reg;
                        out_valid_next = 1'b1;
                        chain_next     = md5he_pkg::CHAIN_INIT;
                        total_next     = '0;
                        in_pad_next    = 1'b0;
                        final_next     = 1'b0;
                        state_next     = md5he_pkg::ST_IDLE;
                    end
                end
                else if (in_pad_reg)
                begin
                    wptr_next  = 5'd0;
                    state_next = md5he_pkg::ST_ZERO;
                end
                else if (last_pend_reg)
                begin
                    state_next = md5he_pkg::ST_PAD;
                end
                else
                begin
                    state_next = md5he_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = md5he_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            block_mem[waddr] <= wdata;
        end
        mem_q <= block_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5he_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= md5he_pkg::CHAIN_INIT;
            acc_reg       <= '0;
            total_reg     <= '0;
            rnd_reg       <= '0;
            wptr_reg      <= '0;
            extra_reg     <= 1'b0;
            in_pad_reg    <= 1'b0;
            final_reg     <= 1'b0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg     <= chain_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            rnd_reg       <= rnd_next;
            wptr_reg      <= wptr_next;
            extra_reg     <= extra_next;
            in_pad_reg    <= in_pad_next;
            final_reg     <= final_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        pre_reg   <= pre_next;
        dig_reg   <= dig_next;
    end

endmodule

@@ tb/md5_hash_engine_tb.sv @@
`timescale 1ns / 1ps

module md5_hash_engine_tb;
    typedef md5he_pkg::word_t word_t;

    typedef logic [3:0][31:0] digest_t;

    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned ITEM_TARGET   = 1550;

    localparam word_t IV_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam word_t SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned ROT_AMT [16] = '{
        7, 12, 17, 22,
        5, 9, 14, 20,
        4, 11, 16, 23,
        6, 10, 15, 21
    };

    logic clk;
    logic rst_n;

    md5he_in_if  msg_if ();
    md5he_out_if dig_if ();

    md5_hash_engine uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (msg_if),
        .digest  (dig_if)
    );

    word_t       hash_chain [4];
    word_t       msg_block [16];
    logic [63:0] msg_len;
    digest_t     expected_digests [$];

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned stall_cycles;
    int unsigned cycle_count;
    int unsigned counted_requests;
    int unsigned byte_requests;
    int unsigned digests_expected;
    int unsigned digests_checked;
    int unsigned mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_message_state();
        foreach (hash_chain[i])
            hash_chain[i] = IV_WORDS[i];
        foreach (msg_block[i])
            msg_block[i] = '0;
        msg_len = '0;
    endfunction

    function automatic void md5_compress();
        word_t       a;
        word_t       b;
        word_t       c;
        word_t       d;
        word_t       f;
        word_t       t;
        int unsigned g;
        int unsigned grp;
        int unsigned sh;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        for (int unsigned r = 0; r < 64; r++)
        begin
            grp = r / 16;
            case (grp)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t  = f + a + SINE_K[r] + msg_block[g];
            sh = ROT_AMT[grp * 4 + r % 4];
            a  = d;
            d  = c;
            c  = b;
            b  = b + ((t << sh) | (t >> (32 - sh)));
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        foreach (msg_block[i])
            msg_block[i] = '0;
    endfunction

    function automatic void predict_request(input logic [7:0] value, input logic present,
                                            input logic is_last);
        int unsigned pos;
        logic [63:0] bit_len;
        if (present)
        begin
            pos = msg_len[5:0];
            msg_block[pos / 4][8 * (pos % 4) +: 8] = value;
            msg_len++;
            byte_requests++;
            if (pos == 63)
                md5_compress();
        end
        if (is_last)
        begin
            pos = msg_len[5:0];
            msg_block[pos / 4][8 * (pos % 4) +: 8] = 8'h80;
            if (pos >= 56)
                md5_compress();
            bit_len = msg_len << 3;
            msg_block[14] = bit_len[31:0];
            msg_block[15] = bit_len[63:32];
            md5_compress();
            expected_digests.push_back({hash_chain[3], hash_chain[2], hash_chain[1],
                                        hash_chain[0]});
            digests_expected++;
            clear_message_state();
        end
    endfunction

    function automatic void check_digest(input digest_t got);
        digest_t want;
        if (expected_digests.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Unexpected digest %h with nothing pending", got);
            return;
        end
        want = expected_digests.pop_front();
        digests_checked++;
        for (int i = 0; i < 4; i++)
        begin
            if (got[i] !== want[i])
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Digest %0d, field digest_%c: expected %h, got %h",
                             digests_checked, 8'h61 + i, want[i], got[i]);
            end
        end
    endfunction

    task automatic send_request(input logic [7:0] value, input logic present,
                                input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.data_byte    <= value;
        msg_if.byte_present <= present;
        msg_if.last         <= is_last;
        do
            @(posedge clk);
        while (!msg_if.ready);
        counted_requests++;
        predict_request(value, present, is_last);
    endtask

    task automatic send_message(input int unsigned len, input int unsigned noise_pct);
        bit end_with_byte;
        end_with_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
        end
        if (!end_with_byte)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_request(8'($urandom), 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_single_byte();
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h3c, 1'b0, 1'b1);
    endtask

    task automatic test_idle_steps();
        send_request(8'ha5, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
    endtask

    task automatic test_extreme_bytes();
        repeat (3)
            send_request(8'hff, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        repeat (3)
            send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_block_boundaries();
        int unsigned lengths [5] = '{55, 56, 63, 64, 120};
        foreach (lengths[i])
            send_message(lengths[i], 0);
    endtask

    task automatic test_output_backpressure();
        stall_cycles = 2000;
        repeat (8)
            send_message($urandom_range(3), 0);
    endtask

    task automatic test_random_messages(input int unsigned n_items);
        int unsigned start;
        int unsigned len;
        start = counted_requests;
        while (counted_requests - start < n_items)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(12);
                6, 7, 8:          len = $urandom_range(72, 52);
                default:          len = $urandom_range(130, 100);
            endcase
            send_message(len, 8);
        end
    endtask

    initial
    begin
        dig_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dig_if.valid && dig_if.ready)
                check_digest({dig_if.digest_d, dig_if.digest_c, dig_if.digest_b,
                              dig_if.digest_a});
            if (stall_cycles > 0)
            begin
                stall_cycles--;
                dig_if.ready <= 1'b0;
            end
            else
                dig_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run timed out after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        msg_if.valid        = 1'b0;
        msg_if.data_byte    = 8'h00;
        msg_if.byte_present = 1'b0;
        msg_if.last         = 1'b0;
        src_idle_pct        = 11;
        sink_idle_pct       = 84;
        stall_cycles        = 0;
        counted_requests    = 0;
        byte_requests       = 0;
        digests_expected    = 0;
        digests_checked     = 0;
        mismatches          = 0;
        clear_message_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_single_byte();
        test_idle_steps();
        test_extreme_bytes();
        test_random_messages(400);

        src_idle_pct  = 84;
        sink_idle_pct = 11;
        test_block_boundaries();
        test_random_messages(300);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_output_backpressure();
        test_random_messages((counted_requests < ITEM_TARGET) ?
                             ITEM_TARGET - counted_requests : 0);

        msg_if.valid <= 1'b0;
        while (expected_digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d digests over %0d requests carrying %0d message bytes.",
                 digests_checked, digests_expected, counted_requests, byte_requests);
        $display("Lengths from empty through several blocks, three idling mixes, long stall.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
